FILE: rtl/fes_pkg.sv
package fes_pkg;

    // schedule modes
    typedef enum logic [2:0] {
        MODE_EXPLORE = 3'd0,
        MODE_EXPLOIT = 3'd1,
        MODE_COE     = 3'd2,
        MODE_FAST    = 3'd3,
        MODE_LIN     = 3'd4,
        MODE_QUAD    = 3'd5
    } t_mode;

    // configuration register indexes
    localparam logic [1:0] CFG_SCHEDULE_MODE  = 2'd0;
    localparam logic [1:0] CFG_MAX_FACTOR     = 2'd1;
    localparam logic [1:0] CFG_POWER_BETA     = 2'd2;
    localparam logic [1:0] CFG_HAVOC_MAX_MULT = 2'd3;

    localparam int unsigned CFG_DATA_W = 11;
    localparam int unsigned SCORE_MAX  = 8191;

    typedef struct packed {
        logic [31:0] exec_time_us;
        logic [16:0] coverage_size;
        logic [15:0] handicap_in;
        logic [15:0] case_depth;
        logic [31:0] hit_count;
        logic [15:0] fuzz_rounds;
        logic [31:0] calib_time_total;
        logic [31:0] calib_cycle_total;
        logic [31:0] coverage_sum;
        logic [31:0] coverage_entries;
        logic [31:0] queue_hit_sum;
        logic [15:0] queue_length;
    } t_item;

    typedef struct packed {
        logic [12:0] energy_score;
        logic [15:0] handicap_out;
        logic        divide_error;
    } t_result;

endpackage

FILE: rtl/fes_div.sv
module fes_div #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_valid,
    output logic [W-1:0] o_quo
);
    // one quotient bit per stage, restoring form
    logic [W-1:0] r_rem [1:W];
    logic [W-1:0] r_nq  [1:W];
    logic [W-1:0] r_den [1:W];
    logic         r_vld [1:W];

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [W-1:0] cur_rem;
        logic [W-1:0] cur_nq;
        logic [W-1:0] cur_den;
        logic         cur_vld;
        logic [W:0]   trial;
        logic         ge;

        if (k == 0) begin : g_first
            assign cur_rem = '0;
            assign cur_nq  = i_num;
            assign cur_den = i_den;
            assign cur_vld = i_valid;
        end else begin : g_next
            assign cur_rem = r_rem[k];
            assign cur_nq  = r_nq[k];
            assign cur_den = r_den[k];
            assign cur_vld = r_vld[k];
        end

        assign trial = {cur_rem, cur_nq[W-1]};
        assign ge    = (trial >= {1'b0, cur_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= cur_vld;
            end
            r_rem[k+1] <= ge ? W'(trial - {1'b0, cur_den}) : trial[W-1:0];
            r_nq[k+1]  <= {cur_nq[W-2:0], ge};
            r_den[k+1] <= cur_den;
        end
    end

    assign o_valid = r_vld[W];
    assign o_quo   = r_nq[W];

endmodule

FILE: rtl/fuzz_energy_score_core.sv
// Energy score pipeline: one transaction accepted every cycle, busy never rises.
// The pipeline depth is set by a 32-stage divider bank (averages, queue mean, factor)
// and an 11-stage divider for the beta division, one quotient bit per stage.
// Reset (synchronous, active low) clears all valid bits and loads register defaults.
// The receiver cannot stall; the output register holds each result for one cycle.
module fuzz_energy_score_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  fes_pkg::t_item               i_item,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_idx,
    input  logic [fes_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                         o_done,
    output fes_pkg::t_result             o_result
);
    import fes_pkg::*;

    localparam int DW = 32;
    localparam int BW = 11;

    typedef struct packed {
        logic [31:0] ex;
        logic [16:0] bs;
        logic [15:0] hc;
        logic [15:0] depth;
        logic [31:0] fz;
        logic [15:0] lvl;
        logic [5:0]  sh;
        logic        err_cc;
        logic        err_ce;
        logic        err_ql;
    } t_side;

    typedef struct packed {
        logic [14:0] p;
        logic [15:0] hc;
        logic        err;
    } t_tail;

    // configuration registers
    t_mode       r_mode;
    logic [10:0] r_max;
    logic [5:0]  r_beta;
    logic [6:0]  r_havoc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_FAST;
            r_max   <= 11'd32;
            r_beta  <= 6'd1;
            r_havoc <= 7'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCHEDULE_MODE:  r_mode  <= t_mode'(i_cfg_data[2:0]);
                CFG_MAX_FACTOR:     r_max   <= i_cfg_data[10:0];
                CFG_POWER_BETA:     r_beta  <= i_cfg_data[5:0];
                CFG_HAVOC_MAX_MULT: r_havoc <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    // stage 0: input register
    logic  r_in_vld;
    t_item r_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= i_start;
        end
        r_in <= i_item;
    end

    // stage 0 logic: divider operands and side data
    logic [31:0] num_f, den_f, fm1;
    logic [5:0]  sh0;
    t_side       side0;

    always_comb begin
        case (r_mode)
            MODE_FAST: num_f = (r_in.fuzz_rounds < 16'd16) ?
                               (32'd1 << r_in.fuzz_rounds[3:0]) : 32'd0;
            MODE_LIN:  num_f = {16'd0, r_in.fuzz_rounds};
            MODE_QUAD: num_f = r_in.fuzz_rounds * r_in.fuzz_rounds;
            default:   num_f = 32'd0;
        endcase
        den_f = (r_in.hit_count == 32'd0) ? 32'd1 : r_in.hit_count;
        // ceil(log2(hit_count)) for the high-level fast case
        fm1 = r_in.hit_count - 32'd1;
        sh0 = 6'd0;
        if (r_in.hit_count > 32'd1) begin
            for (int i = 0; i < 32; i++) begin
                if (fm1[i]) sh0 = 6'(i + 1);
            end
        end
        side0.ex     = r_in.exec_time_us;
        side0.bs     = r_in.coverage_size;
        side0.hc     = r_in.handicap_in;
        side0.depth  = r_in.case_depth;
        side0.fz     = r_in.hit_count;
        side0.lvl    = r_in.fuzz_rounds;
        side0.sh     = sh0;
        side0.err_cc = (r_in.calib_cycle_total == 32'd0);
        side0.err_ce = (r_in.coverage_entries == 32'd0);
        side0.err_ql = (r_in.queue_length == 16'd0);
    end

    // divider bank
    logic        v_avg, v_avgc, v_mu, v_f;
    logic [31:0] q_avg, q_avgc, q_mu, q_f;

    fes_div #(.W(DW)) u_div_avg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_in_vld),
        .i_num(r_in.calib_time_total), .i_den(r_in.calib_cycle_total),
        .o_valid(v_avg), .o_quo(q_avg)
    );
    fes_div #(.W(DW)) u_div_avgc (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_in_vld),
        .i_num(r_in.coverage_sum), .i_den(r_in.coverage_entries),
        .o_valid(v_avgc), .o_quo(q_avgc)
    );
    fes_div #(.W(DW)) u_div_mu (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_in_vld),
        .i_num(r_in.queue_hit_sum), .i_den({16'd0, r_in.queue_length}),
        .o_valid(v_mu), .o_quo(q_mu)
    );
    fes_div #(.W(DW)) u_div_f (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_in_vld),
        .i_num(num_f), .i_den(den_f),
        .o_valid(v_f), .o_quo(q_f)
    );

    // side data delay matching the divider bank
    t_side r_side [1:DW];

    always_ff @(posedge i_clk) begin
        r_side[1] <= side0;
        for (int i = 2; i <= DW; i++) begin
            r_side[i] <= r_side[i-1];
        end
    end

    // stage 1: bands, multipliers and capped factor
    t_side       sd;
    logic [31:0] avg, avgc, mu, fac_raw;
    logic [35:0] avg10, avg4, avg2, avgc10, avgc4, avgc2;
    logic [35:0] ex3, ex4, ex2, bs3, bs2;
    logic [8:0]  p0;
    logic [2:0]  cov, hmul, dmul;
    logic [15:0] hc1;
    logic [10:0] fac_cap;
    logic        err1;

    always_comb begin
        sd     = r_side[DW];
        avg    = sd.err_cc ? 32'd0 : q_avg;
        avgc   = sd.err_ce ? 32'd0 : q_avgc;
        mu     = sd.err_ql ? 32'd0 : q_mu;
        avg10  = 36'(avg) * 36'd10;
        avg4   = 36'(avg) << 2;
        avg2   = 36'(avg) << 1;
        avgc10 = 36'(avgc) * 36'd10;
        avgc4  = 36'(avgc) << 2;
        avgc2  = 36'(avgc) << 1;
        ex3    = 36'(sd.ex) * 36'd3;
        ex4    = 36'(sd.ex) << 2;
        ex2    = 36'(sd.ex) << 1;
        bs3    = 36'(sd.bs) * 36'd3;
        bs2    = 36'(sd.bs) << 1;

        // execution time band
        if (36'(sd.ex) > avg10)       p0 = 9'd10;
        else if (36'(sd.ex) > avg4)   p0 = 9'd25;
        else if (36'(sd.ex) > avg2)   p0 = 9'd50;
        else if (ex3 > avg4)          p0 = 9'd75;
        else if (ex4 < 36'(avg))      p0 = 9'd300;
        else if (ex3 < 36'(avg))      p0 = 9'd200;
        else if (ex2 < 36'(avg))      p0 = 9'd150;
        else                          p0 = 9'd100;

        // coverage band code, applied next stage
        if (bs3 > avgc10)             cov = 3'd0;
        else if (36'(sd.bs) > avgc2)  cov = 3'd1;
        else if (bs3 > avgc4)         cov = 3'd2;
        else if (bs3 < 36'(avgc))     cov = 3'd3;
        else if (bs2 < 36'(avgc))     cov = 3'd4;
        else if (bs3 < avgc2)         cov = 3'd5;
        else                          cov = 3'd6;

        // handicap
        if (sd.hc >= 16'd4) begin
            hmul = 3'd4;
            hc1  = sd.hc - 16'd4;
        end else if (sd.hc != 16'd0) begin
            hmul = 3'd2;
            hc1  = sd.hc - 16'd1;
        end else begin
            hmul = 3'd1;
            hc1  = sd.hc;
        end

        // depth band
        if (sd.depth <= 16'd3)        dmul = 3'd1;
        else if (sd.depth <= 16'd7)   dmul = 3'd2;
        else if (sd.depth <= 16'd13)  dmul = 3'd3;
        else if (sd.depth <= 16'd25)  dmul = 3'd4;
        else                          dmul = 3'd5;

        // schedule factor
        case (r_mode)
            MODE_EXPLOIT: fac_raw = {21'd0, r_max};
            MODE_COE: begin
                if (sd.fz <= mu)
                    fac_raw = (sd.lvl < 16'd16) ? (32'd1 << sd.lvl[3:0]) : {21'd0, r_max};
                else
                    fac_raw = 32'd0;
            end
            MODE_FAST: fac_raw = (sd.lvl < 16'd16) ? q_f : {21'd0, (r_max >> sd.sh)};
            MODE_LIN:  fac_raw = q_f;
            MODE_QUAD: fac_raw = q_f;
            default:   fac_raw = 32'd1;
        endcase
        fac_cap = (fac_raw > {21'd0, r_max}) ? r_max : fac_raw[10:0];

        err1 = sd.err_cc | sd.err_ce | ((r_mode == MODE_COE) & sd.err_ql);
    end

    logic        r_s1_vld;
    logic [8:0]  r_s1_p;
    logic [2:0]  r_s1_cov, r_s1_hmul, r_s1_dmul;
    logic [15:0] r_s1_hc;
    logic [10:0] r_s1_fac;
    logic        r_s1_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= v_avg & v_avgc & v_mu & v_f;
        end
        r_s1_p    <= p0;
        r_s1_cov  <= cov;
        r_s1_hmul <= hmul;
        r_s1_dmul <= dmul;
        r_s1_hc   <= hc1;
        r_s1_fac  <= fac_cap;
        r_s1_err  <= err1;
    end

    // stage 2: apply coverage, handicap and depth multipliers
    logic [9:0]  p1;
    logic [11:0] p2;
    logic [14:0] p3;
    logic [10:0] p_x3;

    always_comb begin
        p_x3 = 11'(r_s1_p) * 11'd3;
        case (r_s1_cov)
            3'd0:    p1 = p_x3[9:0];
            3'd1:    p1 = 10'(r_s1_p) << 1;
            3'd2:    p1 = 10'(p_x3 >> 1);
            3'd3:    p1 = 10'(r_s1_p >> 2);
            3'd4:    p1 = 10'(r_s1_p >> 1);
            3'd5:    p1 = 10'(p_x3 >> 2);
            default: p1 = 10'(r_s1_p);
        endcase
        p2 = 12'(p1) * 12'(r_s1_hmul);
        p3 = 15'(p2) * 15'(r_s1_dmul);
    end

    logic  r_s2_vld;
    logic [10:0] r_s2_fac;
    t_tail r_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_fac <= r_s1_fac;
        r_s2.p   <= p3;
        r_s2.hc  <= r_s1_hc;
        r_s2.err <= r_s1_err;
    end

    // beta division
    logic        v_b;
    logic [10:0] q_b, beta_d;

    assign beta_d = (r_beta == 6'd0) ? 11'd1 : {5'd0, r_beta};

    fes_div #(.W(BW)) u_div_beta (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_s2_vld),
        .i_num(r_s2_fac), .i_den(beta_d),
        .o_valid(v_b), .o_quo(q_b)
    );

    t_tail r_tail [1:BW];

    always_ff @(posedge i_clk) begin
        r_tail[1] <= r_s2;
        for (int i = 2; i <= BW; i++) begin
            r_tail[i] <= r_tail[i-1];
        end
    end

    // output stage: final product and clamp
    logic [25:0] prod;
    logic [13:0] lim_raw;
    logic [12:0] limit, score;

    always_comb begin
        prod    = 26'(r_tail[BW].p) * 26'(q_b);
        lim_raw = 14'(r_havoc) * 14'd100;
        limit   = (lim_raw > 14'(SCORE_MAX)) ? 13'(SCORE_MAX) : lim_raw[12:0];
        score   = (prod > 26'(limit)) ? limit : prod[12:0];
    end

    logic    r_done;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= v_b;
        end
        r_res.energy_score <= score;
        r_res.handicap_out <= r_tail[BW].hc;
        r_res.divide_error <= r_tail[BW].err;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

FILE: rtl/fes_chk.sv
module fes_chk (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_start,
    input logic             o_busy,
    input fes_pkg::t_item   i_item,
    input logic             o_done,
    input fes_pkg::t_result o_result
);
    import fes_pkg::*;

    localparam int LAT = 47;

    // a result strobe only follows an accepted transaction
    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, LAT))
        else $error("result without matching transaction");

    // busy never rises
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy)
        else $error("busy raised");

    // result fully driven while strobed
    a_result_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !$isunknown(o_result))
        else $error("result has unknown bits");

    // handicap never grows
    a_handicap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.handicap_out <= $past(i_item.handicap_in, LAT)))
        else $error("handicap grew");

    // zero calibration count flags a divide error
    a_div_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_item.calib_cycle_total == 32'd0, LAT)) |->
            o_result.divide_error)
        else $error("missing divide error");

endmodule

bind fuzz_energy_score_core fes_chk u_fes_chk (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_start(i_start),
    .o_busy(o_busy),
    .i_item(i_item),
    .o_done(o_done),
    .o_result(o_result)
);
